### src/point_segment_nearest_distance_defines.svh
// Assertion helpers for the nearest-point block.
`ifndef POINT_SEGMENT_NEAREST_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_NEAREST_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSND_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define PSND_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PSND_ASSERT_HOLDS(label, cond, msg)
`define PSND_ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

### src/psnd_pkg.sv
package psnd_pkg;

	// Fraction bits of the projection parameter.
	localparam int LAMBDA_BITS = 24;
	localparam int LAM_W = LAMBDA_BITS + 1;

	// Datapath widths.
	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int DEN_W = PROD_W - 1;
	localparam int REM_W = DEN_W + 1;
	localparam int DIST_W = 33;
	localparam int RAD_W = DEN_W;
	localparam int SQT_W = RAD_W + 2;
	localparam int PW = DIFF_W + LAM_W + 1;
	localparam logic signed [PW-1:0] ROUND_HALF = (PW)'(1) << (LAMBDA_BITS - 1);

	// Queue between the front and the back part.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = FIFO_AW + 1;

	// Configuration port.
	localparam int CFG_IDX_W = 8;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_END1_X = 8'd0,
		REG_END1_Y = 8'd1,
		REG_END2_X = 8'd2,
		REG_END2_Y = 8'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLAMP_INTERIOR = 2'd0,
		CLAMP_END2 = 2'd1,
		CLAMP_END1 = 2'd2,
		CLAMP_DEGEN = 2'd3
	} clamp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] end1_x;
		logic signed [COORD_W-1:0] end1_y;
		logic signed [COORD_W-1:0] end2_x;
		logic signed [COORD_W-1:0] end2_y;
	} seg_t;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		clamp_t code;
		logic [DEN_W-1:0] num;
		logic [DEN_W-1:0] den;
	} work_t;

	typedef struct packed {
		logic [FIFO_CW-1:0] count;
		logic pop;
	} fifo_stat_t;

endpackage

### src/psnd_if.sv
interface psnd_point_if;
	logic valid;
	logic ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	modport source(output valid, point_x, point_y, input ready);
	modport sink(input valid, point_x, point_y, output ready);
endinterface

interface psnd_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] nearest_x;
	logic signed [31:0] nearest_y;
	logic [32:0] distance;
	logic [1:0] clamp_code;
	modport source(output valid, nearest_x, nearest_y, distance, clamp_code, input ready);
	modport sink(input valid, nearest_x, nearest_y, distance, clamp_code, output ready);
endinterface

interface psnd_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### src/psnd_front.sv
module psnd_front (
	input logic clk,
	input logic arst_n,
	psnd_point_if.sink point,
	input psnd_pkg::seg_t seg,
	input psnd_pkg::fifo_stat_t fstat,
	output logic push,
	output psnd_pkg::work_t push_item
);

	logic v_s1, v_s2, v_s3;
	logic accept;
	logic [psnd_pkg::FIFO_CW:0] level;

	logic signed [psnd_pkg::COORD_W-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic signed [psnd_pkg::DIFF_W-1:0] qx_s1, qy_s1, tx_s1, ty_s1;
	logic signed [psnd_pkg::PROD_W-1:0] pqx_s2, pqy_s2, ptx_s2, pty_s2;
	logic signed [psnd_pkg::PROD_W-1:0] num_s3;
	logic [psnd_pkg::DEN_W-1:0] den_s3;
	psnd_pkg::clamp_t code;

	// Credit check: every request in flight has a queue slot reserved.
	assign level = {1'b0, fstat.count} + (psnd_pkg::FIFO_CW + 1)'(v_s1)
		+ (psnd_pkg::FIFO_CW + 1)'(v_s2) + (psnd_pkg::FIFO_CW + 1)'(v_s3);
	assign point.ready = level < (psnd_pkg::FIFO_CW + 1)'(psnd_pkg::FIFO_DEPTH);
	assign accept = point.valid && point.ready;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Differences, products and their sums.
	always_ff @(posedge clk) begin
		px_s1 <= point.point_x;
		py_s1 <= point.point_y;
		qx_s1 <= {point.point_x[31], point.point_x} - {seg.end2_x[31], seg.end2_x};
		qy_s1 <= {point.point_y[31], point.point_y} - {seg.end2_y[31], seg.end2_y};
		tx_s1 <= {seg.end1_x[31], seg.end1_x} - {seg.end2_x[31], seg.end2_x};
		ty_s1 <= {seg.end1_y[31], seg.end1_y} - {seg.end2_y[31], seg.end2_y};
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		pqx_s2 <= qx_s1 * tx_s1;
		pqy_s2 <= qy_s1 * ty_s1;
		ptx_s2 <= tx_s1 * tx_s1;
		pty_s2 <= ty_s1 * ty_s1;
		px_s3 <= px_s2;
		py_s3 <= py_s2;
		num_s3 <= pqx_s2 + pqy_s2;
		den_s3 <= {1'b0, ptx_s2[63:0]} + {1'b0, pty_s2[63:0]};
	end

	// Classify the projection.
	always_comb begin
		if (den_s3 == '0) begin
			code = psnd_pkg::CLAMP_DEGEN;
		end else if (num_s3[psnd_pkg::PROD_W-1]) begin
			code = psnd_pkg::CLAMP_END2;
		end else if (num_s3[psnd_pkg::DEN_W-1:0] > den_s3) begin
			code = psnd_pkg::CLAMP_END1;
		end else begin
			code = psnd_pkg::CLAMP_INTERIOR;
		end
	end

	assign push = v_s3;
	assign push_item.px = px_s3;
	assign push_item.py = py_s3;
	assign push_item.code = code;
	assign push_item.num = (code == psnd_pkg::CLAMP_INTERIOR) ? num_s3[psnd_pkg::DEN_W-1:0] : '0;
	assign push_item.den = den_s3;

endmodule

### src/psnd_fifo.sv
module psnd_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input psnd_pkg::work_t push_item,
	input logic pop,
	output psnd_pkg::work_t head,
	output logic head_valid,
	output psnd_pkg::fifo_stat_t stat
);

	psnd_pkg::work_t mem_q [psnd_pkg::FIFO_DEPTH];
	logic [psnd_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [psnd_pkg::FIFO_CW-1:0] count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign stat.count = count_q;
	assign stat.pop = pop;

endmodule

### src/psnd_back.sv
module psnd_back (
	input logic clk,
	input logic arst_n,
	input psnd_pkg::seg_t seg,
	input psnd_pkg::work_t head,
	input logic head_valid,
	output logic pop,
	psnd_result_if.source result
);

	typedef struct packed {
		logic signed [psnd_pkg::COORD_W-1:0] px;
		logic signed [psnd_pkg::COORD_W-1:0] py;
		psnd_pkg::clamp_t code;
		logic [psnd_pkg::REM_W-1:0] rem;
		logic [psnd_pkg::DEN_W-1:0] den;
		logic [psnd_pkg::LAM_W-1:0] q;
	} div_t;

	typedef struct packed {
		logic signed [psnd_pkg::COORD_W-1:0] fx;
		logic signed [psnd_pkg::COORD_W-1:0] fy;
		psnd_pkg::clamp_t code;
		logic [psnd_pkg::RAD_W-1:0] rad;
		logic [psnd_pkg::DIST_W-1:0] root;
	} sqr_t;

	logic en;
	div_t div_s [psnd_pkg::LAMBDA_BITS+1];
	div_t div_n [psnd_pkg::LAMBDA_BITS+1];
	logic [psnd_pkg::LAMBDA_BITS:0] dv_s;

	logic signed [psnd_pkg::DIFF_W-1:0] tx, ty;
	logic mul_v_s1, near_v_s2, sq_v_s3, sum_v_s4;
	logic signed [psnd_pkg::COORD_W-1:0] mul_px_s1, mul_py_s1, near_px_s2, near_py_s2;
	psnd_pkg::clamp_t mul_code_s1, near_code_s2, sq_code_s3, sum_code_s4;
	logic signed [psnd_pkg::PW-1:0] mul_x_s1, mul_y_s1, rnd_x, rnd_y, sh_x, sh_y;
	logic signed [psnd_pkg::COORD_W-1:0] fx, fy;
	logic signed [psnd_pkg::COORD_W-1:0] near_fx_s2, near_fy_s2, sq_fx_s3, sq_fy_s3;
	logic signed [psnd_pkg::COORD_W-1:0] sum_fx_s4, sum_fy_s4;
	logic signed [psnd_pkg::DIFF_W-1:0] dx, dy;
	logic signed [psnd_pkg::PROD_W-1:0] dsq_x, dsq_y;
	logic [63:0] sq_x_s3, sq_y_s3;
	logic [psnd_pkg::RAD_W-1:0] sum_n_s4;

	sqr_t sqr_first;
	sqr_t sqr_s [psnd_pkg::DIST_W];
	sqr_t sqr_n [psnd_pkg::DIST_W];
	logic [psnd_pkg::DIST_W-1:0] sv_s;

	// The whole back part advances together unless the result is stalled.
	assign en = !result.valid || result.ready;
	assign pop = en && head_valid;

	// Restoring divider, one quotient bit per stage.
	always_comb begin
		logic [psnd_pkg::REM_W-1:0] r0;
		logic [psnd_pkg::REM_W-1:0] sh;
		logic ge;
		r0 = {1'b0, head.num};
		ge = r0 >= {1'b0, head.den};
		div_n[0].px = head.px;
		div_n[0].py = head.py;
		div_n[0].code = head.code;
		div_n[0].den = head.den;
		div_n[0].rem = ge ? r0 - {1'b0, head.den} : r0;
		div_n[0].q = {{(psnd_pkg::LAM_W-1){1'b0}}, ge};
		for (int i = 1; i <= psnd_pkg::LAMBDA_BITS; i++) begin
			sh = {div_s[i-1].rem[psnd_pkg::REM_W-2:0], 1'b0};
			ge = sh >= {1'b0, div_s[i-1].den};
			div_n[i] = div_s[i-1];
			div_n[i].rem = ge ? sh - {1'b0, div_s[i-1].den} : sh;
			div_n[i].q = {div_s[i-1].q[psnd_pkg::LAM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s <= div_n;
		end
	end

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s <= '0;
			mul_v_s1 <= 1'b0;
			near_v_s2 <= 1'b0;
			sq_v_s3 <= 1'b0;
			sum_v_s4 <= 1'b0;
			sv_s <= '0;
		end else if (en) begin
			dv_s <= {dv_s[psnd_pkg::LAMBDA_BITS-1:0], pop};
			mul_v_s1 <= dv_s[psnd_pkg::LAMBDA_BITS];
			near_v_s2 <= mul_v_s1;
			sq_v_s3 <= near_v_s2;
			sum_v_s4 <= sq_v_s3;
			sv_s <= {sv_s[psnd_pkg::DIST_W-2:0], sum_v_s4};
		end
	end

	// Span times lambda.
	assign tx = {seg.end1_x[31], seg.end1_x} - {seg.end2_x[31], seg.end2_x};
	assign ty = {seg.end1_y[31], seg.end1_y} - {seg.end2_y[31], seg.end2_y};

	always_ff @(posedge clk) begin
		if (en) begin
			mul_px_s1 <= div_s[psnd_pkg::LAMBDA_BITS].px;
			mul_py_s1 <= div_s[psnd_pkg::LAMBDA_BITS].py;
			mul_code_s1 <= div_s[psnd_pkg::LAMBDA_BITS].code;
			mul_x_s1 <= tx * $signed({1'b0, div_s[psnd_pkg::LAMBDA_BITS].q});
			mul_y_s1 <= ty * $signed({1'b0, div_s[psnd_pkg::LAMBDA_BITS].q});
		end
	end

	// Round, rescale and pick the nearest point.
	assign rnd_x = mul_x_s1 + psnd_pkg::ROUND_HALF;
	assign rnd_y = mul_y_s1 + psnd_pkg::ROUND_HALF;
	assign sh_x = rnd_x >>> psnd_pkg::LAMBDA_BITS;
	assign sh_y = rnd_y >>> psnd_pkg::LAMBDA_BITS;

	always_comb begin
		unique case (mul_code_s1)
			psnd_pkg::CLAMP_INTERIOR: begin
				fx = seg.end2_x + sh_x[psnd_pkg::COORD_W-1:0];
				fy = seg.end2_y + sh_y[psnd_pkg::COORD_W-1:0];
			end
			psnd_pkg::CLAMP_END1: begin
				fx = seg.end1_x;
				fy = seg.end1_y;
			end
			default: begin
				fx = seg.end2_x;
				fy = seg.end2_y;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_px_s2 <= mul_px_s1;
			near_py_s2 <= mul_py_s1;
			near_code_s2 <= mul_code_s1;
			near_fx_s2 <= fx;
			near_fy_s2 <= fy;
		end
	end

	// Squared offsets and their sum.
	assign dx = {near_px_s2[31], near_px_s2} - {near_fx_s2[31], near_fx_s2};
	assign dy = {near_py_s2[31], near_py_s2} - {near_fy_s2[31], near_fy_s2};
	assign dsq_x = dx * dx;
	assign dsq_y = dy * dy;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_fx_s3 <= near_fx_s2;
			sq_fy_s3 <= near_fy_s2;
			sq_code_s3 <= near_code_s2;
			sq_x_s3 <= dsq_x[63:0];
			sq_y_s3 <= dsq_y[63:0];
			sum_fx_s4 <= sq_fx_s3;
			sum_fy_s4 <= sq_fy_s3;
			sum_code_s4 <= sq_code_s3;
			sum_n_s4 <= {1'b0, sq_x_s3} + {1'b0, sq_y_s3};
		end
	end

	// Integer square root, one result bit per stage, top bit first.
	assign sqr_first.fx = sum_fx_s4;
	assign sqr_first.fy = sum_fy_s4;
	assign sqr_first.code = sum_code_s4;
	assign sqr_first.rad = sum_n_s4;
	assign sqr_first.root = '0;

	always_comb begin
		sqr_t cur;
		logic [psnd_pkg::SQT_W-1:0] trial;
		for (int j = 0; j < psnd_pkg::DIST_W; j++) begin
			cur = (j == 0) ? sqr_first : sqr_s[(j == 0) ? 0 : j - 1];
			trial = ({{(psnd_pkg::SQT_W - psnd_pkg::DIST_W){1'b0}}, cur.root}
					<< (psnd_pkg::DIST_W - j))
				+ ({{(psnd_pkg::SQT_W - 1){1'b0}}, 1'b1} << (2 * (psnd_pkg::DIST_W - 1 - j)));
			sqr_n[j] = cur;
			if ({2'b00, cur.rad} >= trial) begin
				sqr_n[j].rad = cur.rad - trial[psnd_pkg::RAD_W-1:0];
				sqr_n[j].root = cur.root
					| ({{(psnd_pkg::DIST_W - 1){1'b0}}, 1'b1} << (psnd_pkg::DIST_W - 1 - j));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqr_s <= sqr_n;
		end
	end

	// The last root stage is the output register.
	assign result.valid = sv_s[psnd_pkg::DIST_W-1];
	assign result.nearest_x = sqr_s[psnd_pkg::DIST_W-1].fx;
	assign result.nearest_y = sqr_s[psnd_pkg::DIST_W-1].fy;
	assign result.distance = sqr_s[psnd_pkg::DIST_W-1].root;
	assign result.clamp_code = sqr_s[psnd_pkg::DIST_W-1].code;

endmodule

### src/point_segment_nearest_distance.sv
// Throughput: one request per cycle while the output is not stalled and credits remain;
// the 25-stage divider and 33-stage root pipeline set depth.
// An 8-entry queue between the classifying front part and the back part absorbs stalls.
// Reset clears all valid bits and the queue count, and sets the endpoint registers to zero.
`include "point_segment_nearest_distance_defines.svh"

module point_segment_nearest_distance (
	input logic clk,
	input logic arst_n,
	psnd_point_if.sink point,
	psnd_result_if.source result,
	psnd_cfg_if.sink cfg
);

	psnd_pkg::seg_t seg;
	psnd_pkg::fifo_stat_t fstat;
	psnd_pkg::work_t push_item, head;
	logic push, pop, head_valid;

	// Endpoint registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				psnd_pkg::REG_END1_X: seg.end1_x <= cfg.data;
				psnd_pkg::REG_END1_Y: seg.end1_y <= cfg.data;
				psnd_pkg::REG_END2_X: seg.end2_x <= cfg.data;
				psnd_pkg::REG_END2_Y: seg.end2_y <= cfg.data;
				default: seg <= seg;
			endcase
		end
	end

	psnd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.point(point),
		.seg(seg),
		.fstat(fstat),
		.push(push),
		.push_item(push_item)
	);

	psnd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.head_valid(head_valid),
		.stat(fstat)
	);

	psnd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.seg(seg),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.result(result)
	);

	// Credits keep the queue from overflowing.
	`PSND_ASSERT_HOLDS(a_fifo_bound, fstat.count <= (psnd_pkg::FIFO_CW)'(psnd_pkg::FIFO_DEPTH), "queue over depth")
	`PSND_ASSERT_IMPLIES(a_push_room, push, fstat.count < (psnd_pkg::FIFO_CW)'(psnd_pkg::FIFO_DEPTH) || fstat.pop, "push into full queue")
	// A degenerate segment always answers with the second endpoint.
	`PSND_ASSERT_IMPLIES(a_degen_end2, result.valid && result.clamp_code == psnd_pkg::CLAMP_DEGEN, result.nearest_x == seg.end2_x && result.nearest_y == seg.end2_y, "degenerate result off endpoint")

endmodule

### dv/psnd_tb_if.sv
// The channel interfaces come with the RTL sources; this file holds the expected-result type.
package psnd_tb_pkg;
	import psnd_pkg::*;

	// One expected nearest-point result.
	typedef struct packed {
		logic signed [31:0] nearest_x;
		logic signed [31:0] nearest_y;
		logic [32:0] distance;
		clamp_t code;
	} nearest_t;
endpackage

### dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import psnd_pkg::*;
	import psnd_tb_pkg::*;

	// Tracks the segment endpoints and the nearest points still owed by the block.
	class nearest_board;
		logic signed [31:0] e1x, e1y, e2x, e2y;
		nearest_t pending[$];
		int errors;

		function new();
			e1x = 0;
			e1y = 0;
			e2x = 0;
			e2y = 0;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [31:0] v);
			case (idx)
				REG_END1_X: e1x = v;
				REG_END1_Y: e1y = v;
				REG_END2_X: e2x = v;
				REG_END2_Y: e2y = v;
				default: ;
			endcase
		endfunction

		function logic [33:0] root(logic [65:0] n);
			logic [33:0] r;
			logic [33:0] c;
			r = 0;
			for (int b = 33; b >= 0; b--) begin
				c = r | (34'd1 << b);
				if ({34'd0, c} * {34'd0, c} <= {2'd0, n}) r = c;
			end
			return r;
		endfunction

		// Rounded interpolation from the second endpoint along the segment.
		function logic signed [31:0] lerp(logic signed [31:0] b, logic signed [32:0] span,
				logic [24:0] lam);
			logic signed [63:0] p;
			p = 64'(span) * $signed({39'd0, lam}) + 64'sd8388608;
			p = p >>> 24;
			return b + p[31:0];
		endfunction

		function void note_point(logic signed [31:0] px, logic signed [31:0] py);
			logic signed [32:0] tx, ty, qx, qy, dx, dy;
			logic signed [67:0] num, den, rem;
			logic [24:0] lam;
			nearest_t n;
			tx = 33'(e1x) - 33'(e2x);
			ty = 33'(e1y) - 33'(e2y);
			qx = 33'(px) - 33'(e2x);
			qy = 33'(py) - 33'(e2y);
			den = 68'(tx) * 68'(tx) + 68'(ty) * 68'(ty);
			num = 68'(qx) * 68'(tx) + 68'(qy) * 68'(ty);
			if (den == 0) begin
				n.nearest_x = e2x; n.nearest_y = e2y; n.code = CLAMP_DEGEN;
			end else if (num < 0) begin
				n.nearest_x = e2x; n.nearest_y = e2y; n.code = CLAMP_END2;
			end else if (num > den) begin
				n.nearest_x = e1x; n.nearest_y = e1y; n.code = CLAMP_END1;
			end else begin
				// Restoring division for the 24-bit projection fraction.
				lam = 0;
				rem = num;
				if (rem >= den) begin
					rem = rem - den;
					lam = 1;
				end
				for (int i = 0; i < 24; i++) begin
					rem = rem <<< 1;
					lam = lam << 1;
					if (rem >= den) begin
						rem = rem - den;
						lam[0] = 1'b1;
					end
				end
				n.nearest_x = lerp(e2x, tx, lam);
				n.nearest_y = lerp(e2y, ty, lam);
				n.code = CLAMP_INTERIOR;
			end
			dx = 33'(px) - 33'(n.nearest_x);
			dy = 33'(py) - 33'(n.nearest_y);
			n.distance = 33'(root(66'(68'(dx) * 68'(dx) + 68'(dy) * 68'(dy))));
			pending.push_back(n);
		endfunction

		function void check(nearest_t got);
			nearest_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.nearest_x !== w.nearest_x)
				$display("%0t: nearest_x expected %0d actual %0d", $time, w.nearest_x,
					got.nearest_x);
			if (got.nearest_y !== w.nearest_y)
				$display("%0t: nearest_y expected %0d actual %0d", $time, w.nearest_y,
					got.nearest_y);
			if (got.distance !== w.distance)
				$display("%0t: distance expected %0d actual %0d", $time, w.distance,
					got.distance);
			if (got.code !== w.code)
				$display("%0t: clamp_code expected %0d actual %0d", $time, w.code, got.code);
			if (got !== w) errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	bit calm = 0;
	bit done = 0;
	nearest_board board = new();

	psnd_point_if point();
	psnd_result_if result();
	psnd_cfg_if cfg();

	point_segment_nearest_distance i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point(point.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		point.valid = 0;
		point.point_x = 0;
		point.point_y = 0;
		result.ready = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
	end

	// Output side: random stalls except during the calm stretch.
	always @(posedge clk) begin
		if (result.valid && result.ready)
			board.check({result.nearest_x, result.nearest_y, result.distance,
				clamp_t'(result.clamp_code)});
		result.ready <= calm || ($urandom_range(99) >= 35);
	end

	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		board.set_reg(idx, v);
		cfg.valid <= 0;
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y);
		while (!calm && $urandom_range(99) < 35) begin
			point.valid <= 0;
			@(posedge clk);
		end
		point.valid <= 1;
		point.point_x <= x;
		point.point_y <= y;
		@(posedge clk);
		while (!point.ready) @(posedge clk);
		board.note_point(x, y);
	endtask

	task automatic drain();
		point.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic load_segment(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d);
		write_reg(REG_END1_X, a);
		write_reg(REG_END1_Y, b);
		write_reg(REG_END2_X, c);
		write_reg(REG_END2_Y, d);
	endtask

	// Mostly small coordinates, with occasional full-range or extreme values.
	function automatic logic [31:0] pick();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return $urandom;
			default: return $signed($urandom_range(2 ** 21)) - 32'sd1048576;
		endcase
	endfunction

	initial begin
		logic [31:0] lo, hi;
		lo = 32'h8000_0000;
		hi = 32'h7fff_ffff;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Degenerate segment straight out of reset, with extreme points.
		send_point(lo, lo);
		send_point(hi, hi);
		send_point(lo, hi);
		drain();

		// Extreme diagonal: both ends, interior, exact parameter values; then a short segment with clamps.
		load_segment(hi, hi, lo, lo);
		send_point(lo, lo);
		send_point(hi, hi);
		send_point(0, 0);
		send_point(lo, hi);
		send_point(hi, lo);
		send_point(32'h0001_0000, 32'hffff_0000);
		drain();
		load_segment(32'h0001_0000, 0, 0, 0);
		send_point(32'hffff_0000, 32'h0005_0000);
		send_point(32'h0003_0000, 32'hfffb_0000);
		send_point(32'h0000_8000, 32'h0000_0001);
		send_point(0, 0);
		send_point(32'h0001_0000, 0);
		send_point(hi, lo);
		drain();

		// Random phases over fresh segments; the last two run without stalls.
		for (int ph = 0; ph < 15; ph++) begin
			calm = (ph >= 13);
			if (ph % 5 == 4)
				load_segment(pick(), pick(), pick(), pick());
			else if (ph % 5 == 3) begin
				lo = pick();
				hi = pick();
				load_segment(lo, hi, lo, hi);
			end else
				load_segment(pick(), pick(), pick(), pick());
			repeat (100) send_point(pick(), pick());
			drain();
		end

		if (board.errors == 0)
			$display("point_segment_nearest_distance: match");
		else
			$display("point_segment_nearest_distance: mismatch");
		done = 1;
		$finish;
	end

	initial begin
		#2ms;
		if (!done) $display("point_segment_nearest_distance: mismatch");
		$finish;
	end
endmodule

### point_segment_nearest_distance.f
+incdir+src
src/psnd_pkg.sv
src/psnd_if.sv
src/psnd_front.sv
src/psnd_fifo.sv
src/psnd_back.sv
src/point_segment_nearest_distance.sv
dv/psnd_tb_if.sv
dv/testbench.sv
